// ===== rtl/core/arm_dp_pkg.sv =====
// opcode codes and write-back control bundle for the arm data-processing alu
// no dependencies
`timescale 1ns / 1ps

package arm_dp_pkg;

    localparam int unsigned DataWidth = 32;

    typedef logic [DataWidth-1:0] word_t;
    typedef logic [3:0] opcode_t;
    typedef logic [3:0] reg_idx_t;

    localparam opcode_t OP_AND = 4'd0;
    localparam opcode_t OP_EOR = 4'd1;
    localparam opcode_t OP_SUB = 4'd2;
    localparam opcode_t OP_RSB = 4'd3;
    localparam opcode_t OP_ADD = 4'd4;
    localparam opcode_t OP_ADC = 4'd5;
    localparam opcode_t OP_SBC = 4'd6;
    localparam opcode_t OP_RSC = 4'd7;
    localparam opcode_t OP_TST = 4'd8;
    localparam opcode_t OP_TEQ = 4'd9;
    localparam opcode_t OP_CMP = 4'd10;
    localparam opcode_t OP_CMN = 4'd11;
    localparam opcode_t OP_ORR = 4'd12;
    localparam opcode_t OP_MOV = 4'd13;
    localparam opcode_t OP_BIC = 4'd14;
    localparam opcode_t OP_MVN = 4'd15;

    localparam reg_idx_t PC_INDEX = 4'd15;

    typedef struct packed {
        logic write_result;
        logic flags_write;
        logic restore_status;
        logic undefined;
    } ctrl_t;

endpackage

// ===== rtl/core/arm_data_processing_alu.sv =====
// arm data-processing alu: sixteen opcodes, nzcv flags, pc-destination handling
// depends on arm_dp_pkg
// the done strobe follows the start edge through the input register and then the result register
// throughput: one item per cycle; busy is always low, the adder path sets the clock
// reset: rst_n asynchronous active low clears the valid bits only, no state is kept
// the receiver cannot stall: each result is shown for exactly one cycle under done
`timescale 1ns / 1ps

module arm_data_processing_alu
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  arm_dp_pkg::opcode_t  req_type,
    input  arm_dp_pkg::word_t    first_operand,
    input  arm_dp_pkg::word_t    second_operand,
    input  logic                 shifter_carry,
    input  logic                 carry_flag,
    input  logic                 overflow_in,
    input  logic                 set_flags,
    input  arm_dp_pkg::reg_idx_t dest_reg,
    input  logic                 mode_has_saved_status,
    output logic                 done,
    output arm_dp_pkg::word_t    result,
    output logic                 write_result,
    output arm_dp_pkg::reg_idx_t dest_index,
    output logic                 flag_n,
    output logic                 flag_z,
    output logic                 flag_c,
    output logic                 flag_v,
    output logic                 flags_write,
    output logic                 restore_status,
    output logic                 undefined
);

    import arm_dp_pkg::*;

    // input stage
    logic     in_valid_reg;
    opcode_t  op_reg;
    word_t    a_reg;
    word_t    b_reg;
    logic     sc_reg;
    logic     cin_reg;
    logic     vin_reg;
    logic     s_reg;
    reg_idx_t rd_reg;
    logic     spsr_reg;

    // result stage
    logic     done_reg;
    word_t    result_reg;
    word_t    result_next;
    reg_idx_t rd_out_reg;
    logic     n_reg;
    logic     z_reg;
    logic     c_reg;
    logic     v_reg;
    logic     c_next;
    logic     v_next;
    ctrl_t    ctrl_reg;
    ctrl_t    ctrl_next;

    word_t               add_x;
    word_t               add_y;
    logic                add_ci;
    logic [DataWidth:0]  add_sum;
    word_t               add_r;
    logic                add_co;
    logic                add_ov;
    logic                arith;
    logic                compare;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= req_type;
            a_reg    <= first_operand;
            b_reg    <= second_operand;
            sc_reg   <= shifter_carry;
            cin_reg  <= carry_flag;
            vin_reg  <= overflow_in;
            s_reg    <= set_flags;
            rd_reg   <= dest_reg;
            spsr_reg <= mode_has_saved_status;
        end
    end

    // shared adder operand select
    always_comb
    begin
        add_x  = a_reg;
        add_y  = b_reg;
        add_ci = 1'b0;
        arith  = 1'b1;
        case (op_reg)
            OP_SUB, OP_CMP:
            begin
                add_y  = ~b_reg;
                add_ci = 1'b1;
            end
            OP_RSB:
            begin
                add_x  = b_reg;
                add_y  = ~a_reg;
                add_ci = 1'b1;
            end
            OP_ADD, OP_CMN:
            begin
                add_ci = 1'b0;
            end
            OP_ADC:
            begin
                add_ci = cin_reg;
            end
            OP_SBC:
            begin
                add_y  = ~b_reg;
                add_ci = cin_reg;
            end
            OP_RSC:
            begin
                add_x  = b_reg;
                add_y  = ~a_reg;
                add_ci = cin_reg;
            end
            default:
            begin
                arith = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{DataWidth{1'b0}}, add_ci};
    assign add_r   = add_sum[DataWidth-1:0];
    assign add_co  = add_sum[DataWidth];
    assign add_ov  = (add_x[DataWidth-1] ^ add_r[DataWidth-1])
                   & (add_y[DataWidth-1] ^ add_r[DataWidth-1]);

    always_comb
    begin
        case (op_reg)
            OP_AND, OP_TST: result_next = a_reg & b_reg;
            OP_EOR, OP_TEQ: result_next = a_reg ^ b_reg;
            OP_ORR:         result_next = a_reg | b_reg;
            OP_MOV:         result_next = b_reg;
            OP_BIC:         result_next = a_reg & ~b_reg;
            OP_MVN:         result_next = ~b_reg;
            default:        result_next = add_r;
        endcase
        c_next = arith ? add_co : sc_reg;
        v_next = arith ? add_ov : vin_reg;
    end

    // write-back and status control
    always_comb
    begin
        compare   = op_reg inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN};
        ctrl_next = '0;
        if (compare)
        begin
            ctrl_next.flags_write = 1'b1;
        end
        else if (s_reg && (rd_reg == PC_INDEX))
        begin
            if (spsr_reg)
            begin
                ctrl_next.write_result   = 1'b1;
                ctrl_next.restore_status = 1'b1;
            end
            else
            begin
                ctrl_next.undefined = 1'b1;
            end
        end
        else
        begin
            ctrl_next.write_result = 1'b1;
            ctrl_next.flags_write  = s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            result_reg <= result_next;
            rd_out_reg <= rd_reg;
            n_reg      <= result_next[DataWidth-1];
            z_reg      <= (result_next == '0);
            c_reg      <= c_next;
            v_reg      <= v_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    assign done           = done_reg;
    assign result         = result_reg;
    assign write_result   = ctrl_reg.write_result;
    assign dest_index     = rd_out_reg;
    assign flag_n         = n_reg;
    assign flag_z         = z_reg;
    assign flag_c         = c_reg;
    assign flag_v         = v_reg;
    assign flags_write    = ctrl_reg.flags_write;
    assign restore_status = ctrl_reg.restore_status;
    assign undefined      = ctrl_reg.undefined;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> ##1 done)
        else $error("item accepted without a result two cycles later");

    a_undef_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && undefined) |-> (!write_result && !flags_write && !restore_status))
        else $error("undefined item still writes state");

    a_restore_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (done && restore_status) |-> (write_result && (dest_index == PC_INDEX) && !flags_write))
        else $error("status restore without pc write");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (flag_z == (result == '0)) && (flag_n == result[DataWidth-1]))
        else $error("n or z flag disagrees with result");

endmodule
